// ===== rtl/command_frame_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// Command frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_RECEIVER_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define CFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("command_frame_receiver assertion failed");

// next-cycle implication
`define CFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("command_frame_receiver assertion failed");

`endif

// ===== rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Command frame receiver package
// Phase and event codes, register indexes and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgStartByte = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxArgLen = 2'd1;

  localparam logic [7:0] StartByteReset = 8'd0;
  localparam logic [7:0] MaxArgLenReset = 8'd99;

  typedef enum logic [2:0] {
    PhWait  = 3'd0,
    PhCmd   = 3'd1,
    PhLen   = 3'd2,
    PhArgs  = 3'd3,
    PhCheck = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EvArg     = 2'd0,
    EvAccept  = 2'd1,
    EvBadSum  = 2'd2,
    EvTooLong = 2'd3
  } event_e;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] command;
    logic [7:0] arg_len;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    logic [7:0] computed_check;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/command_frame_receiver.sv =====
// Results: a beat for an accepted byte is registered into the output queue.
// Throughput: one byte per cycle; the two-entry output queue lets input run
// on while a result waits, and stalls input only when both entries are held.
// Reset: asynchronous, active low; clears the frame state, the queue and
// sets start_byte to 0 and max_arg_len to 99.
// ----------------------------------------------------------------------------
// Command frame receiver
// Deframes length-prefixed command packets with an XOR check byte.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        rx_valid_i,
  output logic                        rx_ready_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [1:0]                  event_res_o,
  output logic [7:0]                  command_o,
  output logic [7:0]                  arg_len_o,
  output logic [7:0]                  byte_index_o,
  output logic [7:0]                  byte_value_o,
  output logic [7:0]                  computed_check_o
);
  import cfr_pkg::*;

  logic rx_fire;
  logic res_push;
  logic fifo_full;
  res_t res_new;
  res_t res_head;

  assign rx_ready_o = ~fifo_full;
  assign rx_fire    = rx_valid_i & rx_ready_o;

  cfr_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx_fire_i   (rx_fire),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_push),
    .res_o       (res_new)
  );

  cfr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_new),
    .full_o      (fifo_full),
    .valid_o     (res_valid_o),
    .pop_i       (res_valid_o & res_ready_i),
    .data_o      (res_head)
  );

  assign event_res_o      = res_head.event_res;
  assign command_o        = res_head.command;
  assign arg_len_o        = res_head.arg_len;
  assign byte_index_o     = res_head.byte_index;
  assign byte_value_o     = res_head.byte_value;
  assign computed_check_o = res_head.computed_check;

endmodule

`default_nettype wire

// ===== rtl/cfr_deframer.sv =====
// ----------------------------------------------------------------------------
// Command frame receiver deframer
// Frame phase tracking, running XOR check and result generation per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        rx_fire_i,
  input  logic [7:0]                  rx_byte_i,
  output logic                        res_valid_o,
  output cfr_pkg::res_t               res_o
);
  import cfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] start_byte_q, max_arg_len_q;
  logic [7:0] frame_command_q, frame_command_d;
  logic [7:0] frame_length_q, frame_length_d;
  logic [7:0] args_received_q, args_received_d;
  logic [7:0] running_check_q, running_check_d;
  logic [7:0] check_xor;
  logic [7:0] args_inc;
  logic       too_long;

  assign check_xor = running_check_q ^ rx_byte_i;
  assign args_inc  = args_received_q + 8'd1;
  assign too_long  = rx_byte_i > max_arg_len_q;

  always_comb begin
    phase_d = phase_q;
    if (rx_fire_i) begin
      case (phase_q)
        PhCmd: phase_d = PhLen;
        PhLen: begin
          if (too_long) begin
            phase_d = PhWait;
          end else if (rx_byte_i != 8'd0) begin
            phase_d = PhArgs;
          end else begin
            phase_d = PhCheck;
          end
        end
        PhArgs: begin
          if (args_inc == frame_length_q) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: phase_d = PhWait;
        default: begin
          phase_d = (rx_byte_i == start_byte_q) ? PhCmd : PhWait;
        end
      endcase
    end
  end

  always_comb begin
    frame_command_d          = frame_command_q;
    frame_length_d           = frame_length_q;
    args_received_d          = args_received_q;
    running_check_d          = running_check_q;
    res_valid_o              = 1'b0;
    res_o.event_res          = EvArg;
    res_o.command            = frame_command_q;
    res_o.arg_len            = frame_length_q;
    res_o.byte_index         = 8'd0;
    res_o.byte_value         = rx_byte_i;
    res_o.computed_check     = check_xor;
    if (rx_fire_i) begin
      case (phase_q)
        PhCmd: begin
          frame_command_d = rx_byte_i;
          running_check_d = check_xor;
        end
        PhLen: begin
          running_check_d = check_xor;
          if (too_long) begin
            res_valid_o      = 1'b1;
            res_o.event_res  = EvTooLong;
            res_o.arg_len    = rx_byte_i;
            res_o.byte_value = 8'd0;
          end else begin
            frame_length_d  = rx_byte_i;
            args_received_d = 8'd0;
          end
        end
        PhArgs: begin
          running_check_d  = check_xor;
          args_received_d  = args_inc;
          res_valid_o      = 1'b1;
          res_o.byte_index = args_received_q;
        end
        PhCheck: begin
          res_valid_o          = 1'b1;
          res_o.event_res      = (rx_byte_i == running_check_q) ? EvAccept : EvBadSum;
          res_o.computed_check = running_check_q;
        end
        default: begin
          if (rx_byte_i == start_byte_q) begin
            running_check_d = rx_byte_i;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PhWait;
      frame_command_q <= 8'd0;
      frame_length_q  <= 8'd0;
      args_received_q <= 8'd0;
      running_check_q <= 8'd0;
    end else begin
      phase_q         <= phase_d;
      frame_command_q <= frame_command_d;
      frame_length_q  <= frame_length_d;
      args_received_q <= args_received_d;
      running_check_q <= running_check_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q  <= StartByteReset;
      max_arg_len_q <= MaxArgLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartByte: start_byte_q  <= cfg_data_i;
        CfgMaxArgLen: max_arg_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfr_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Command frame receiver output buffer
// Two-entry result queue that decouples the byte input from the result output.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfr_pkg::res_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output cfr_pkg::res_t data_o
);
  import cfr_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// Command frame receiver checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_frame_receiver_macros.svh"

module cfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_o,
  input logic       res_ready_i,
  input logic [1:0] event_res_o,
  input logic [7:0] command_o,
  input logic [7:0] arg_len_o,
  input logic [7:0] byte_index_o,
  input logic [7:0] byte_value_o,
  input logic [7:0] computed_check_o
);
  import cfr_pkg::*;

  logic [41:0] res_beat;

  assign res_beat = {event_res_o, command_o, arg_len_o, byte_index_o, byte_value_o,
                     computed_check_o};

  `CFR_ASSERT_NEXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(res_beat))
  `CFR_ASSERT_NOW(a_arg_index, res_valid_o && (event_res_o == EvArg), byte_index_o < arg_len_o)
  `CFR_ASSERT_NOW(a_end_index, res_valid_o && (event_res_o != EvArg), byte_index_o == 8'd0)
  `CFR_ASSERT_NOW(a_long_value, res_valid_o && (event_res_o == EvTooLong), byte_value_o == 8'd0)

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (.*);

`default_nettype wire

// ===== verif/command_frame_receiver_test.sv =====
// ----------------------------------------------------------------------------
// Command frame receiver testbench
// Feeds serial bytes to the deframer and tracks its frame state in a local
// copy. Every result beat is checked field by field against the oldest
// predicted event. Directed frames exercise the length limits, the check
// byte and register writes made part-way through a frame. Random traffic
// then runs under three idling mixes and one long output stall.
// ----------------------------------------------------------------------------
module command_frame_receiver_test;

  import cfr_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare3 = 2'd3;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = CfgStartByte;
  logic [7:0]          cfg_data   = 8'd0;
  logic                rx_valid   = 1'b0;
  logic [7:0]          rx_byte    = 8'd0;
  logic                res_ready  = 1'b0;

  logic                rx_ready;
  logic                res_valid;
  logic [1:0]          event_res;
  logic [7:0]          command;
  logic [7:0]          arg_len;
  logic [7:0]          byte_index;
  logic [7:0]          byte_value;
  logic [7:0]          computed_check;

  // local copy of the deframer
  logic [7:0]  cfg_start = StartByteReset;
  logic [7:0]  cfg_max   = MaxArgLenReset;
  phase_e      rx_phase  = PhWait;
  logic [7:0]  frame_cmd = 8'd0;
  logic [7:0]  frame_len = 8'd0;
  logic [7:0]  arg_count = 8'd0;
  logic [7:0]  xor_check = 8'd0;

  res_t        expected_events[$];
  int unsigned frame_bytes   = 0;
  int unsigned beat_count    = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned tx_idle_pct   = 10;
  int unsigned rx_idle_pct   = 10;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  command_frame_receiver dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .rx_valid_i       (rx_valid),
    .rx_ready_o       (rx_ready),
    .rx_byte_i        (rx_byte),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .event_res_o      (event_res),
    .command_o        (command),
    .arg_len_o        (arg_len),
    .byte_index_o     (byte_index),
    .byte_value_o     (byte_value),
    .computed_check_o (computed_check)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_event(event_e ev, logic [7:0] len, logic [7:0] idx,
                                     logic [7:0] val);
    res_t r;
    r.event_res      = ev;
    r.command        = frame_cmd;
    r.arg_len        = len;
    r.byte_index     = idx;
    r.byte_value     = val;
    r.computed_check = xor_check;
    expected_events.push_back(r);
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] idx;
    case (rx_phase)
      PhCmd: begin
        frame_cmd = b;
        xor_check ^= b;
        rx_phase = PhLen;
        frame_bytes++;
      end
      PhLen: begin
        xor_check ^= b;
        frame_bytes++;
        if (b > cfg_max) begin
          rx_phase = PhWait;
          push_event(EvTooLong, b, 8'd0, 8'd0);
        end else begin
          frame_len = b;
          arg_count = 8'd0;
          if (b != 8'd0) rx_phase = PhArgs;
          else rx_phase = PhCheck;
        end
      end
      PhArgs: begin
        idx = arg_count;
        xor_check ^= b;
        arg_count++;
        frame_bytes++;
        if (arg_count == frame_len) rx_phase = PhCheck;
        push_event(EvArg, frame_len, idx, b);
      end
      PhCheck: begin
        rx_phase = PhWait;
        frame_bytes++;
        if (b == xor_check) push_event(EvAccept, frame_len, 8'd0, b);
        else push_event(EvBadSum, frame_len, 8'd0, b);
      end
      default: begin
        rx_phase = PhWait;
        if (b == cfg_start) begin
          xor_check = b;
          rx_phase = PhCmd;
          frame_bytes++;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("beat %0d: %s got %02h want %02h", beat_count, field, got, want);
    mismatches++;
  endtask

  task automatic check_result_beat();
    res_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("unexpected beat, event", {6'd0, event_res}, 8'd0);
    end else begin
      want = expected_events.pop_front();
      if (event_res !== want.event_res)
        report_mismatch("event_res", {6'd0, event_res}, {6'd0, want.event_res});
      if (command !== want.command) report_mismatch("command", command, want.command);
      if (arg_len !== want.arg_len) report_mismatch("arg_len", arg_len, want.arg_len);
      if (byte_index !== want.byte_index)
        report_mismatch("byte_index", byte_index, want.byte_index);
      if (byte_value !== want.byte_value)
        report_mismatch("byte_value", byte_value, want.byte_value);
      if (computed_check !== want.computed_check)
        report_mismatch("computed_check", computed_check, want.computed_check);
    end
    beat_count++;
  endtask

  // result side: check accepted beats, then choose ready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (res_valid && res_ready) check_result_beat();
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    deframe_byte(b);
  endtask

  task automatic wait_results_drained();
    rx_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CfgStartByte: cfg_start = data;
      CfgMaxArgLen: cfg_max = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] len, input bit corrupt);
    logic [7:0] cmd;
    logic [7:0] arg;
    logic [7:0] chk;
    cmd = 8'($urandom);
    chk = cfg_start ^ cmd ^ len;
    send_byte(cfg_start);
    send_byte(cmd);
    send_byte(len);
    if (len <= cfg_max) begin
      for (int i = 0; i < len; i++) begin
        arg = 8'($urandom);
        chk ^= arg;
        send_byte(arg);
      end
      if (corrupt) chk ^= 8'($urandom_range(1, 255));
      send_byte(chk);
    end
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00 ^ 8'hFF ^ 8'h00);
    wait_results_drained();
  endtask

  task automatic test_length_limits();
    cfg_write(CfgStartByte, 8'hA5);
    cfg_write(CfgMaxArgLen, 8'd2);
    send_byte(8'hA5);
    send_byte(8'h00);
    send_byte(8'd3);
    // start byte inside a frame is plain data; length equal to the limit
    send_byte(8'hA5);
    send_byte(8'h80);
    send_byte(8'd2);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'hA5 ^ 8'h80 ^ 8'd2 ^ 8'hFF ^ 8'hA5 ^ 8'h01);
    wait_results_drained();
    cfg_write(CfgMaxArgLen, 8'd0);
    cfg_write(CfgStartByte, 8'hFF);
    send_byte(8'hFF);
    send_byte(8'h07);
    send_byte(8'd0);
    send_byte(8'hFF ^ 8'h07 ^ 8'd0);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'd1);
    wait_results_drained();
  endtask

  task automatic test_midframe_config();
    send_byte(8'hFF);
    send_byte(8'h3C);
    wait_results_drained();
    cfg_write(CfgStartByte, 8'h5A);
    cfg_write(CfgMaxArgLen, 8'd1);
    cfg_write(CfgIdxSpare2, 8'h00);
    cfg_write(CfgIdxSpare3, 8'hFF);
    send_byte(8'd1);
    send_byte(8'h5A);
    send_byte(8'hFF ^ 8'h3C ^ 8'd1 ^ 8'h5A);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input logic [7:0] start_val,
                                     input logic [7:0] max_val,
                                     input int unsigned goal);
    int unsigned first;
    int unsigned pick;
    int unsigned len;
    wait_results_drained();
    cfg_write(CfgStartByte, start_val);
    cfg_write(CfgMaxArgLen, max_val);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first = frame_bytes;
    while (frame_bytes - first < goal) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(49) == 0) len = $urandom_range(0, cfg_max);
        else if (cfg_max <= 16 && $urandom_range(9) == 0) len = cfg_max;
        else len = $urandom_range(0, (cfg_max < 8) ? cfg_max : 8);
        send_frame(8'(len), $urandom_range(99) < 25);
      end else if (pick < 85) begin
        send_byte(8'($urandom));
      end else if (pick < 95 && cfg_max != 8'hFF) begin
        send_frame(8'($urandom_range(cfg_max + 1, 255)), 1'b0);
      end else begin
        // cut-off frame: following bytes fall into it
        send_byte(cfg_start);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      end
    end
    wait_results_drained();
  endtask

  task automatic test_output_stall();
    wait_results_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 80;
    repeat (4) send_frame(8'd8, 1'b0);
    wait_results_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_length_limits();
    test_midframe_config();
    test_random_traffic(22, 87, 8'h7E, 8'hFF, 380);
    test_random_traffic(87, 22, 8'($urandom), 8'($urandom_range(1, 12)), 380);
    test_random_traffic(0, 0, 8'($urandom), 8'($urandom_range(2, 16)), 380);
    test_output_stall();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
